[hdl/lfoss_pkg.sv]
package lfoss_pkg;

    localparam int PHASE_W = 24;
    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 4;
    localparam int OUT_W   = 9;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SYNC  = 2'd1;
    localparam logic [1:0] OP_NOTE  = 2'd2;
    localparam logic [1:0] OP_RATE  = 2'd3;

    localparam logic [2:0] MODE_INTERNAL = 3'd0;
    localparam logic [2:0] MODE_DIV4     = 3'd1;
    localparam logic [2:0] MODE_DIV2     = 3'd2;
    localparam logic [2:0] MODE_X1       = 3'd3;
    localparam logic [2:0] MODE_X2       = 3'd4;
    localparam logic [2:0] MODE_X4       = 3'd5;

    localparam logic [1:0] REG_CLOCK_MODE  = 2'd0;
    localparam logic [1:0] REG_TEMPO       = 2'd1;
    localparam logic [1:0] REG_GATE_LENGTH = 2'd2;
    localparam logic [1:0] REG_STEP_LEVELS = 2'd3;

    localparam logic [COUNT_W-1:0] TEMPO_DIVISOR = 16'd15;
    localparam logic [5:0] GATE_OPEN = 6'd32;

    function automatic logic [OUT_W-1:0] exp_value(input logic [LEVEL_W-1:0] lvl);
        logic [OUT_W-1:0] v;
        case (lvl)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd15;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd48;
            4'd4:    v = 9'd67;
            4'd5:    v = 9'd86;
            4'd6:    v = 9'd106;
            4'd7:    v = 9'd128;
            4'd8:    v = 9'd150;
            4'd9:    v = 9'd175;
            4'd10:   v = 9'd200;
            4'd11:   v = 9'd227;
            4'd12:   v = 9'd256;
            4'd13:   v = 9'd286;
            4'd14:   v = 9'd319;
            default: v = 9'd353;
        endcase
        return v;
    endfunction

    function automatic logic [PHASE_W-1:0] sync_dividend(input logic [2:0] mode);
        logic [PHASE_W-1:0] v;
        case (mode)
            MODE_DIV4: v = 24'h07ffff;
            MODE_DIV2: v = 24'h0fffff;
            MODE_X1:   v = 24'h1fffff;
            MODE_X2:   v = 24'h3fffff;
            MODE_X4:   v = 24'h7fffff;
            default:   v = 24'h000000;
        endcase
        return v;
    endfunction

endpackage

[hdl/lfoss_in_if.sv]
interface lfoss_in_if
    import lfoss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] gate_mod;
    logic [15:0]        song_position;
    logic               compute_step;
    logic [2:0]         knob_index;

    modport source (output valid, opcode, gate_mod, song_position, compute_step,
                    knob_index, input ready);
    modport sink (input valid, opcode, gate_mod, song_position, compute_step,
                  knob_index, output ready);
endinterface

[hdl/lfoss_out_if.sv]
interface lfoss_out_if
    import lfoss_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] level;
    logic             gate_closed;

    modport source (output valid, level, gate_closed, input ready);
    modport sink (input valid, level, gate_closed, output ready);
endinterface

[hdl/lfo_step_sequencer.sv]
// Flow: a tick passes S_EXEC, S_GATE, S_SLEW and S_DONE; note on, ignored items and rate
// update without a division pass S_EXEC and S_DONE; clock sync without a division adds
// S_SYNC; rate update with a division adds S_DIV, and clock sync with one adds S_DIV
// before S_SYNC (24 steps of the shared divider). Throughput: one item at a time; ready
// returns as the result enters the output register, which holds it until taken.
// Reset: rst_n async low clears FSM and phase state to zero and config to defaults.
module lfo_step_sequencer
    import lfoss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    lfoss_in_if.sink    in_ch,
    lfoss_out_if.source out_ch
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_GATE = 7'b0000100,
        S_SLEW = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SYNC = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  clock_mode_reg;
    logic [7:0]  tempo_reg;
    logic [5:0]  gate_length_reg;
    logic [63:0] step_levels_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] phase_step_reg, phase_step_next;
    logic [COUNT_W-1:0] tick_count_reg, tick_count_next;
    logic               gated_reg, gated_next;
    logic [LEVEL_W-1:0] target_reg, target_next;
    logic [LEVEL_W-1:0] current_reg, current_next;

    logic [1:0]  op_reg;
    logic [8:0]  mod_reg;
    logic [15:0] sp_reg;
    logic        compute_reg;
    logic [2:0]  knob_reg;

    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [PHASE_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0]   divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_level_reg, out_level_next;
    logic             out_gate_reg, out_gate_next;

    logic               accept;
    logic               sync_ok;
    logic               rate_ok;
    logic signed [9:0]  gsum;
    logic [19:0]        edge_pos;
    logic [LEVEL_W-1:0] step_level;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   rem_shift;

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.level    = out_level_reg;
    assign out_ch.gate_closed = out_gate_reg;

    assign sync_ok = (clock_mode_reg >= MODE_DIV4) && (clock_mode_reg <= MODE_X4) && !sp_reg[0];
    assign rate_ok = (knob_reg < 3'd2) && (clock_mode_reg == MODE_INTERNAL);

    assign gsum       = $signed({4'b0000, gate_length_reg}) + $signed({mod_reg[8], mod_reg});
    assign edge_pos   = {gsum[4:0], 15'b0};
    assign step_level = step_levels_reg[{phase_reg[23:20], 2'b00} +: LEVEL_W];

    assign rem_shift = {rem_reg, quo_reg[PHASE_W-1]};
    assign trial     = rem_shift - {1'b0, divisor_reg};

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        phase_step_next = phase_step_reg;
        tick_count_next = tick_count_reg;
        gated_next      = gated_reg;
        target_next     = target_reg;
        current_next    = current_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        divisor_next    = divisor_reg;
        div_cnt_next    = div_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_level_next  = out_level_reg;
        out_gate_next   = out_gate_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (tick_count_reg != {COUNT_W{1'b1}})
                        begin
                            tick_count_next = tick_count_reg + COUNT_W'(1);
                        end
                        phase_next = phase_reg + phase_step_reg;
                        state_next = S_GATE;
                    end
                    OP_SYNC:
                    begin
                        if (sync_ok)
                        begin
                            if (compute_reg && (tick_count_reg != '0))
                            begin
                                rem_next     = '0;
                                quo_next     = sync_dividend(clock_mode_reg);
                                divisor_next = tick_count_reg;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                            else
                            begin
                                state_next = S_SYNC;
                            end
                        end
                    end
                    OP_NOTE:
                    begin
                        if (clock_mode_reg == MODE_INTERNAL)
                        begin
                            phase_next  = '0;
                            target_next = step_levels_reg[LEVEL_W-1:0];
                        end
                    end
                    default:
                    begin
                        if (rate_ok)
                        begin
                            rem_next     = '0;
                            quo_next     = {6'b0, tempo_reg, 10'b0};
                            divisor_next = TEMPO_DIVISOR;
                            div_cnt_next = '0;
                            state_next   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (!trial[COUNT_W])
                begin
                    rem_next = trial[COUNT_W-1:0];
                    quo_next = {quo_reg[PHASE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[COUNT_W-1:0];
                    quo_next = {quo_reg[PHASE_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(PHASE_W - 1))
                begin
                    phase_step_next = quo_next;
                    if (op_reg == OP_SYNC)
                    begin
                        tick_count_next = '0;
                        state_next      = S_SYNC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SYNC:
            begin
                case (clock_mode_reg)
                    MODE_DIV4:
                    begin
                        if (sp_reg[1:0] == 2'b00)
                        begin
                            phase_next = {sp_reg[5:2], 20'b0};
                        end
                        else
                        begin
                            phase_next = {sp_reg[5:2], phase_reg[19:0]};
                        end
                    end
                    MODE_DIV2: phase_next = {sp_reg[4:1], 20'b0};
                    MODE_X1:   phase_next = {sp_reg[3:0], 20'b0};
                    MODE_X2:   phase_next = {sp_reg[2:0], 1'b0, 20'b0};
                    default:   phase_next = {sp_reg[1:0], 2'b00, 20'b0};
                endcase
                state_next = S_DONE;
            end
            S_GATE:
            begin
                if (gsum <= 10'sd0)
                begin
                    target_next = '0;
                end
                else if (gsum < $signed({4'b0000, GATE_OPEN}))
                begin
                    if (!gated_reg && (phase_reg[19:0] >= edge_pos))
                    begin
                        target_next = '0;
                        gated_next  = 1'b1;
                    end
                    else if (gated_reg && (phase_reg[19:0] < edge_pos))
                    begin
                        target_next = step_level;
                        gated_next  = 1'b0;
                    end
                end
                else
                begin
                    target_next = step_level;
                end
                state_next = S_SLEW;
            end
            S_SLEW:
            begin
                if (current_reg < target_reg)
                begin
                    current_next = current_reg + LEVEL_W'(1);
                end
                else if (current_reg > target_reg)
                begin
                    current_next = current_reg - LEVEL_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = exp_value(current_reg);
                    out_gate_next  = gated_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            clock_mode_reg  <= MODE_INTERNAL;
            tempo_reg       <= 8'd120;
            gate_length_reg <= GATE_OPEN;
            step_levels_reg <= '0;
            phase_reg       <= '0;
            phase_step_reg  <= '0;
            tick_count_reg  <= '0;
            gated_reg       <= 1'b0;
            target_reg      <= '0;
            current_reg     <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            phase_step_reg <= phase_step_next;
            tick_count_reg <= tick_count_next;
            gated_reg      <= gated_next;
            target_reg     <= target_next;
            current_reg    <= current_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CLOCK_MODE:  clock_mode_reg  <= cfg_data[2:0];
                    REG_TEMPO:       tempo_reg       <= cfg_data[7:0];
                    REG_GATE_LENGTH: gate_length_reg <= cfg_data[5:0];
                    default:         step_levels_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        divisor_reg   <= divisor_next;
        out_level_reg <= out_level_next;
        out_gate_reg  <= out_gate_next;
        if (accept)
        begin
            op_reg      <= in_ch.opcode;
            mod_reg     <= in_ch.gate_mod[15:7];
            sp_reg      <= in_ch.song_position;
            compute_reg <= in_ch.compute_step;
            knob_reg    <= in_ch.knob_index;
        end
    end

endmodule
